@@ hdl/dcc_pkg.sv @@
package dcc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned COUNT_WIDTH     = 8;
  localparam int unsigned ORDER_WIDTH     = 2;

  localparam logic [ORDER_WIDTH-1:0] ORDER_LESS  = 2'd0;
  localparam logic [ORDER_WIDTH-1:0] ORDER_EQUAL = 2'd1;
  localparam logic [ORDER_WIDTH-1:0] ORDER_MORE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_WAIT,
    ST_DONE
  } state_e;

  // result of one remainder operation
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

@@ hdl/dcc_rem_unit.sv @@
module dcc_rem_unit #(
  parameter int unsigned VALUE_WIDTH = dcc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_WIDTH-1:0]  dividend_i,
  input  logic [VALUE_WIDTH-1:0]  divisor_i,
  output dcc_pkg::rem_status_t    status_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] dsr_q, dsr_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   take;

  // restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign take  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = take ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

@@ hdl/divisor_count_compare_top.sv @@
// Counts the proper divisors of two unsigned values by trial division and
// reports both counts (saturated at 255) together with the order of the first
// count against the second. Candidates d = 1, 2, ... are tried while d*d <= n,
// each divisor d found adding itself and its partner n/d, or only itself when
// d*d = n; the square d*d is kept by running addition. Every candidate goes
// through one shared restoring remainder unit, and values below two skip the
// trial loop with a count of zero. The two values are handled one after the
// other. in_stall_o stays high while an item is being worked on; one finished
// result may wait in the output register while the next item is taken.
module divisor_count_compare_top #(
  parameter int unsigned VALUE_WIDTH = dcc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [VALUE_WIDTH-1:0]               first_value_i,
  input  logic [VALUE_WIDTH-1:0]               second_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [dcc_pkg::ORDER_WIDTH-1:0]      order_o,
  output logic [dcc_pkg::COUNT_WIDTH-1:0]      first_count_o,
  output logic [dcc_pkg::COUNT_WIDTH-1:0]      second_count_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = (W > dcc_pkg::COUNT_WIDTH) ? W : dcc_pkg::COUNT_WIDTH;

  dcc_pkg::state_e     state_q, state_d;
  dcc_pkg::rem_status_t rem_status;

  logic         sel_q, sel_d;
  logic [W-1:0] val_a_q, val_a_d;
  logic [W-1:0] val_b_q, val_b_d;
  logic [W-1:0] d_q, d_d;
  logic [W+1:0] sq_q, sq_d;
  logic [W-1:0] total_q, total_d;
  logic [W-1:0] cnt_a_q, cnt_a_d;
  logic [W-1:0] cnt_b_q, cnt_b_d;

  logic                              out_valid_q, out_valid_d;
  logic [dcc_pkg::ORDER_WIDTH-1:0]   order_q, order_d;
  logic [dcc_pkg::COUNT_WIDTH-1:0]   first_count_q, first_count_d;
  logic [dcc_pkg::COUNT_WIDTH-1:0]   second_count_q, second_count_d;

  logic [W-1:0] n;
  logic         accept;
  logic         div_start;
  logic         fin;
  logic [W-1:0] fin_cnt;
  logic         load;
  logic [CW-1:0] cnt_a_ext, cnt_b_ext;

  assign n      = sel_q ? val_b_q : val_a_q;
  assign accept = in_valid_i && !in_stall_o;

  assign in_stall_o = (state_q != dcc_pkg::ST_IDLE);

  assign cnt_a_ext = CW'(cnt_a_q);
  assign cnt_b_ext = CW'(cnt_b_q);

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    val_a_d   = val_a_q;
    val_b_d   = val_b_q;
    d_d       = d_q;
    sq_d      = sq_q;
    total_d   = total_q;
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    div_start = 1'b0;
    fin       = 1'b0;
    fin_cnt   = '0;
    load      = 1'b0;

    unique case (state_q)
      dcc_pkg::ST_IDLE: begin
        if (accept) begin
          val_a_d = first_value_i;
          val_b_d = second_value_i;
          sel_d   = 1'b0;
          state_d = dcc_pkg::ST_START;
        end
      end
      dcc_pkg::ST_START: begin
        d_d     = W'(1);
        sq_d    = (W+2)'(1);
        total_d = '0;
        if (n < W'(2)) begin
          fin = 1'b1;
        end else begin
          state_d = dcc_pkg::ST_CHECK;
        end
      end
      dcc_pkg::ST_CHECK: begin
        if (sq_q > {2'b00, n}) begin
          // every found divisor pair is in; drop n itself
          fin     = 1'b1;
          fin_cnt = total_q - 1'b1;
        end else begin
          div_start = 1'b1;
          state_d   = dcc_pkg::ST_WAIT;
        end
      end
      dcc_pkg::ST_WAIT: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            total_d = total_q + ((sq_q == {2'b00, n}) ? W'(1) : W'(2));
          end
          // (d+1)^2 = d^2 + 2d + 1
          sq_d    = sq_q + {1'b0, d_q, 1'b1};
          d_d     = d_q + 1'b1;
          state_d = dcc_pkg::ST_CHECK;
        end
      end
      dcc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = dcc_pkg::ST_IDLE;
        end
      end
      default: state_d = dcc_pkg::ST_IDLE;
    endcase

    if (fin) begin
      if (!sel_q) begin
        cnt_a_d = fin_cnt;
        sel_d   = 1'b1;
        state_d = dcc_pkg::ST_START;
      end else begin
        cnt_b_d = fin_cnt;
        state_d = dcc_pkg::ST_DONE;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d    = out_valid_q;
    order_d        = order_q;
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (cnt_a_q < cnt_b_q) begin
        order_d = dcc_pkg::ORDER_LESS;
      end else if (cnt_a_q == cnt_b_q) begin
        order_d = dcc_pkg::ORDER_EQUAL;
      end else begin
        order_d = dcc_pkg::ORDER_MORE;
      end
      first_count_d  = (cnt_a_ext > CW'(255)) ? '1 : cnt_a_ext[dcc_pkg::COUNT_WIDTH-1:0];
      second_count_d = (cnt_b_ext > CW'(255)) ? '1 : cnt_b_ext[dcc_pkg::COUNT_WIDTH-1:0];
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcc_pkg::ST_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_a_q        <= val_a_d;
    val_b_q        <= val_b_d;
    d_q            <= d_d;
    sq_q           <= sq_d;
    total_q        <= total_d;
    cnt_a_q        <= cnt_a_d;
    cnt_b_q        <= cnt_b_d;
    order_q        <= order_d;
    first_count_q  <= first_count_d;
    second_count_q <= second_count_d;
  end

  dcc_rem_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n),
    .divisor_i (d_q),
    .status_o  (rem_status)
  );

  assign out_valid_o    = out_valid_q;
  assign order_o        = order_q;
  assign first_count_o  = first_count_q;
  assign second_count_o = second_count_q;

endmodule

@@ hdl/dcc_checker.sv @@
module dcc_checker #(
  parameter int unsigned VALUE_WIDTH = dcc_pkg::VALUE_WIDTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [VALUE_WIDTH-1:0]            first_value_i,
  input logic [VALUE_WIDTH-1:0]            second_value_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [dcc_pkg::ORDER_WIDTH-1:0]   order_o,
  input logic [dcc_pkg::COUNT_WIDTH-1:0]   first_count_o,
  input logic [dcc_pkg::COUNT_WIDTH-1:0]   second_count_o
);

  // a held result keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(order_o)
      && $stable(first_count_o) && $stable(second_count_o))
    else $error("held result changed");

  // the block is busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("ready straight after a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (first_count_o < second_count_o) |-> order_o == dcc_pkg::ORDER_LESS)
    else $error("order does not match smaller first count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (first_count_o > second_count_o) |-> order_o == dcc_pkg::ORDER_MORE)
    else $error("order does not match larger first count");

  // equal unsaturated counts must report equal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (first_count_o == second_count_o) && (first_count_o != '1)
      |-> order_o == dcc_pkg::ORDER_EQUAL)
    else $error("order does not match equal counts");

endmodule

bind divisor_count_compare_top dcc_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_dcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .first_value_i (first_value_i),
  .second_value_i(second_value_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .order_o       (order_o),
  .first_count_o (first_count_o),
  .second_count_o(second_count_o)
);
